// File: design/dert_pkg.sv
// Shared types and constants for the event slot table.
package dert_pkg;

    typedef enum logic [2:0] {
        FUNC_SETUP   = 3'd0,
        FUNC_START   = 3'd1,
        FUNC_STOP    = 3'd2,
        FUNC_CLEAR   = 3'd3,
        FUNC_REPORT  = 3'd4,
        FUNC_TICK    = 3'd5,
        FUNC_TRIGGER = 3'd6,
        FUNC_UNKNOWN = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SETUP,
        OP_START,
        OP_STOP,
        OP_CLEAR,
        OP_REPORT,
        OP_TICK,
        OP_TRIGGER
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_COND     = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    localparam logic [1:0] REG_WINDOW      = 2'd0;
    localparam logic [1:0] REG_FAST        = 2'd1;
    localparam logic [1:0] REG_MEDIUM      = 2'd2;
    localparam logic [1:0] REG_SLOW        = 2'd3;

    localparam logic [7:0] WINDOW_INFINITE = 8'h02;
    localparam logic [7:0] KIND_STATUS     = 8'h01;
    localparam logic [7:0] KIND_TIMER      = 8'h02;
    localparam logic [7:0] KIND_IDENT      = 8'h03;
    localparam logic [7:0] KIND_COMPARE    = 8'h07;
    localparam logic [7:0] KIND_MASK       = 8'h7F;
    localparam logic [7:0] CMP_GREATER     = 8'h02;
    localparam logic [7:0] CMP_LESS        = 8'h03;
    localparam logic [31:0] RATE_FAST      = 32'h3;
    localparam logic [31:0] RATE_MEDIUM    = 32'h2;
    localparam logic [7:0] SID_ROE         = 8'h86;
    localparam logic [7:0] SID_SECURED     = 8'h84;
    localparam int         MAX_LISTED      = 8;

    typedef struct packed {
        cell_op_t    op;
        logic [7:0]  etype;
        logic [31:0] value;
        logic [7:0]  cmp;
        logic [7:0]  win;
        logic [31:0] now;
        logic [31:0] deadline;
        logic [31:0] fast_period;
        logic [31:0] medium_period;
        logic [31:0] slow_period;
    } cell_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] kind;
    } cell_stat_t;

endpackage

// File: design/dert_cell.sv
// One event slot: holds its state, answers a step and passes the free flag on.
module dert_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dert_pkg::cell_cmd_t    cmd,
    input  logic                   en,
    input  logic                   free_in,
    output logic                   free_out,
    output dert_pkg::cell_stat_t   stat
);

    logic        used_reg, used_next;
    logic        armed_reg, armed_next;
    logic        primed_reg, primed_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] ref_reg, ref_next;
    logic [7:0]  cmp_reg, cmp_next;
    logic [7:0]  win_reg, win_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] next_fire_reg, next_fire_next;

    logic        active;
    logic        expired;
    logic        timer;
    logic        fire_due;
    logic        match;
    logic        hit;
    logic [31:0] period;
    logic [31:0] dl_diff;
    logic [31:0] nf_diff;
    logic [7:0]  new_kind;

    assign free_out = free_in | ~used_reg;
    assign active   = used_reg & armed_reg;
    assign dl_diff  = cmd.now - deadline_reg;
    assign nf_diff  = cmd.now - next_fire_reg;
    assign expired  = (win_reg != dert_pkg::WINDOW_INFINITE) & ~dl_diff[31];
    assign timer    = (kind_reg == dert_pkg::KIND_TIMER);
    assign fire_due = ~nf_diff[31];
    assign new_kind = cmd.etype & dert_pkg::KIND_MASK;

    always_comb
    begin
        if (ref_reg == dert_pkg::RATE_FAST)
        begin
            period = cmd.fast_period;
        end
        else if (ref_reg == dert_pkg::RATE_MEDIUM)
        begin
            period = cmd.medium_period;
        end
        else
        begin
            period = cmd.slow_period;
        end
    end

    always_comb
    begin
        if (kind_reg == dert_pkg::KIND_IDENT)
        begin
            match = (cmd.value == ref_reg);
        end
        else if (kind_reg == dert_pkg::KIND_COMPARE)
        begin
            if (cmp_reg == dert_pkg::CMP_GREATER)
            begin
                match = (cmd.value > ref_reg);
            end
            else if (cmp_reg == dert_pkg::CMP_LESS)
            begin
                match = (cmd.value < ref_reg);
            end
            else
            begin
                match = (cmd.value == ref_reg);
            end
        end
        else
        begin
            match = ((cmd.value & ref_reg) != 32'd0);
        end
    end

    always_comb
    begin
        case (cmd.op)
            dert_pkg::OP_REPORT:  hit = active;
            dert_pkg::OP_TICK:    hit = active & ~expired & timer & primed_reg & fire_due;
            dert_pkg::OP_TRIGGER: hit = active & (kind_reg == cmd.etype) & match;
            default:              hit = 1'b0;
        endcase
    end

    assign stat.hit  = hit;
    assign stat.kind = kind_reg;

    always_comb
    begin
        used_next      = used_reg;
        armed_next     = armed_reg;
        primed_next    = primed_reg;
        kind_next      = kind_reg;
        ref_next       = ref_reg;
        cmp_next       = cmp_reg;
        win_next       = win_reg;
        deadline_next  = deadline_reg;
        next_fire_next = next_fire_reg;
        if (en)
        begin
            case (cmd.op)
                dert_pkg::OP_SETUP:
                begin
                    if (~used_reg & ~free_in)
                    begin
                        used_next      = 1'b1;
                        armed_next     = 1'b0;
                        primed_next    = 1'b0;
                        kind_next      = new_kind;
                        ref_next       = cmd.value;
                        cmp_next       = (new_kind == dert_pkg::KIND_COMPARE) ? cmd.cmp : 8'd0;
                        win_next       = cmd.win;
                        deadline_next  = 32'd0;
                        next_fire_next = 32'd0;
                    end
                end
                dert_pkg::OP_START:
                begin
                    if (used_reg)
                    begin
                        armed_next    = 1'b1;
                        deadline_next = (win_reg == dert_pkg::WINDOW_INFINITE) ?
                                        32'd0 : cmd.deadline;
                    end
                end
                dert_pkg::OP_STOP:
                begin
                    armed_next = 1'b0;
                end
                dert_pkg::OP_CLEAR:
                begin
                    used_next   = 1'b0;
                    armed_next  = 1'b0;
                    primed_next = 1'b0;
                end
                dert_pkg::OP_TICK:
                begin
                    if (active)
                    begin
                        if (expired)
                        begin
                            armed_next = 1'b0;
                        end
                        else if (timer)
                        begin
                            if (~primed_reg)
                            begin
                                primed_next    = 1'b1;
                                next_fire_next = cmd.now + period;
                            end
                            else if (fire_due)
                            begin
                                next_fire_next = cmd.now + period;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            armed_reg  <= 1'b0;
            primed_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            armed_reg  <= armed_next;
            primed_reg <= primed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        ref_reg       <= ref_next;
        cmp_reg       <= cmp_next;
        win_reg       <= win_next;
        deadline_reg  <= deadline_next;
        next_fire_reg <= next_fire_next;
    end

endmodule

// File: design/diagnostic_event_response_table.sv
// Top level of the event slot table: command control, slot chain and result register.
//
//  Channel  Signals                                          Direction
//  in       in_valid/in_ready, func .. now_ms                into block
//  out      out_valid/out_ready, status .. last              out of block
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         into block
//
// Setup, start, stop, clear: the result is registered from ST_SINGLE once the output
// is free, and the block then returns to ST_IDLE for the next transaction.
// Report, tick, trigger: ST_SCAN walks the chain slot by slot, then ST_FINAL gives the
// final result.
// A stalled result holds the slot walk; the next transaction is taken once the
// walk is done. Reset empties all slots at once; cfg writes always complete.
module diagnostic_event_response_table #(
    parameter int SLOTS       = 8,
    parameter int REQUEST_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  evt_type,
    input  logic [31:0] event_value,
    input  logic [7:0]  compare_op,
    input  logic [7:0]  window_code,
    input  logic [7:0]  request_len,
    input  logic [7:0]  request_first_byte,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        fire,
    output logic [2:0]  slot_index,
    output logic [7:0]  type_out,
    output logic [3:0]  count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    dert_pkg::state_t state_reg, state_next;

    logic [31:0] window_reg, fast_reg, medium_reg, slow_reg;

    logic [2:0]  func_reg;
    logic [7:0]  etype_reg;
    logic [31:0] value_reg;
    logic [7:0]  cmp_reg;
    logic [7:0]  win_reg;
    logic [7:0]  rlen_reg;
    logic [7:0]  first_reg;
    logic [31:0] now_reg;

    logic [IW-1:0] idx_reg, idx_next;
    logic [3:0]    listed_reg, listed_next;
    logic [3:0]    fired_reg, fired_next;
    logic [CW-1:0] used_cnt_reg, used_cnt_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic       fire_reg, fire_next;
    logic [2:0] slot_index_reg, slot_index_next;
    logic [7:0] type_out_reg, type_out_next;
    logic [3:0] count_reg, count_next;
    logic       last_reg, last_next;

    dert_pkg::cell_cmd_t  cmd;
    dert_pkg::cell_stat_t stat [SLOTS];
    logic [SLOTS:0]       free_chain;
    logic [SLOTS-1:0]     cell_en;

    logic       out_free;
    logic       single_go;
    logic       step_go;
    logic       step_hit;
    logic       step_emit;
    logic [7:0] kind_sel;
    logic [7:0] new_kind;
    logic       kind_ok;
    logic       len_bad;
    logic       nest;
    logic       full;
    logic [1:0] setup_status;
    logic [3:0] used_sat;
    logic [3:0] used_inc_sat;
    logic       is_scan;

    assign out_free  = ~out_valid_reg | out_ready;
    assign in_ready  = (state_reg == dert_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign fire       = fire_reg;
    assign slot_index = slot_index_reg;
    assign type_out   = type_out_reg;
    assign count      = count_reg;
    assign last       = last_reg;

    assign new_kind = etype_reg & dert_pkg::KIND_MASK;
    assign kind_ok  = (new_kind == dert_pkg::KIND_STATUS) || (new_kind == dert_pkg::KIND_TIMER)
                   || (new_kind == dert_pkg::KIND_IDENT) || (new_kind == dert_pkg::KIND_COMPARE);
    assign len_bad  = (rlen_reg == 8'd0) || (32'(rlen_reg) > 32'(REQUEST_MAX));
    assign nest     = (first_reg == dert_pkg::SID_ROE) || (first_reg == dert_pkg::SID_SECURED);
    assign full     = (used_cnt_reg == CW'(SLOTS));

    always_comb
    begin
        if (!kind_ok)
        begin
            setup_status = dert_pkg::STATUS_RANGE;
        end
        else if (len_bad)
        begin
            setup_status = dert_pkg::STATUS_COND;
        end
        else if (nest)
        begin
            setup_status = dert_pkg::STATUS_RANGE;
        end
        else if (full)
        begin
            setup_status = dert_pkg::STATUS_COND;
        end
        else
        begin
            setup_status = dert_pkg::STATUS_OK;
        end
    end

    assign used_sat     = (32'(used_cnt_reg) > 32'd15) ? 4'd15 : 4'(used_cnt_reg);
    assign used_inc_sat = (32'(used_cnt_reg) + 32'd1 > 32'd15) ? 4'd15 :
                          4'(32'(used_cnt_reg) + 32'd1);

    always_comb
    begin
        case (dert_pkg::func_t'(func_reg))
            dert_pkg::FUNC_SETUP:
                cmd.op = (setup_status == dert_pkg::STATUS_OK) ?
                         dert_pkg::OP_SETUP : dert_pkg::OP_NONE;
            dert_pkg::FUNC_START:   cmd.op = dert_pkg::OP_START;
            dert_pkg::FUNC_STOP:    cmd.op = dert_pkg::OP_STOP;
            dert_pkg::FUNC_CLEAR:   cmd.op = dert_pkg::OP_CLEAR;
            dert_pkg::FUNC_REPORT:  cmd.op = dert_pkg::OP_REPORT;
            dert_pkg::FUNC_TICK:    cmd.op = dert_pkg::OP_TICK;
            dert_pkg::FUNC_TRIGGER: cmd.op = dert_pkg::OP_TRIGGER;
            default:                cmd.op = dert_pkg::OP_NONE;
        endcase
    end

    assign cmd.etype         = etype_reg;
    assign cmd.value         = value_reg;
    assign cmd.cmp           = cmp_reg;
    assign cmd.win           = win_reg;
    assign cmd.now           = now_reg;
    assign cmd.deadline      = now_reg + window_reg;
    assign cmd.fast_period   = fast_reg;
    assign cmd.medium_period = medium_reg;
    assign cmd.slow_period   = slow_reg;

    assign is_scan = (cmd.op == dert_pkg::OP_REPORT) || (cmd.op == dert_pkg::OP_TICK)
                  || (cmd.op == dert_pkg::OP_TRIGGER);

    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        assign cell_en[g] = single_go | (step_go & (idx_reg == IW'(g)));
        dert_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .en       (cell_en[g]),
            .free_in  (free_chain[g]),
            .free_out (free_chain[g+1]),
            .stat     (stat[g])
        );
    end

    assign step_hit  = stat[idx_reg].hit;
    assign kind_sel  = stat[idx_reg].kind;
    assign step_emit = step_hit & (listed_reg < 4'(dert_pkg::MAX_LISTED));
    assign single_go = (state_reg == dert_pkg::ST_SINGLE) & out_free & ~is_scan;
    assign step_go   = (state_reg == dert_pkg::ST_SCAN) & (~step_emit | out_free);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        listed_next     = listed_reg;
        fired_next      = fired_reg;
        used_cnt_next   = used_cnt_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        status_next     = status_reg;
        fire_next       = fire_reg;
        slot_index_next = slot_index_reg;
        type_out_next   = type_out_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        case (state_reg)
            dert_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dert_pkg::ST_SINGLE;
                end
            end
            dert_pkg::ST_SINGLE:
            begin
                if (is_scan)
                begin
                    idx_next    = '0;
                    listed_next = 4'd0;
                    fired_next  = 4'd0;
                    state_next  = dert_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    fire_next       = 1'b0;
                    slot_index_next = 3'd0;
                    type_out_next   = 8'd0;
                    last_next       = 1'b1;
                    status_next     = dert_pkg::STATUS_OK;
                    count_next      = used_sat;
                    case (dert_pkg::func_t'(func_reg))
                        dert_pkg::FUNC_SETUP:
                        begin
                            status_next = setup_status;
                            count_next  = 4'd0;
                            if (setup_status == dert_pkg::STATUS_OK)
                            begin
                                used_cnt_next = used_cnt_reg + CW'(1);
                                count_next    = used_inc_sat;
                                type_out_next = new_kind;
                                for (int i = 0; i < SLOTS; i++)
                                begin
                                    if (~free_chain[i] & free_chain[i+1])
                                    begin
                                        slot_index_next = 3'(i);
                                    end
                                end
                            end
                        end
                        dert_pkg::FUNC_CLEAR:
                        begin
                            used_cnt_next = '0;
                            count_next    = 4'd0;
                        end
                        dert_pkg::FUNC_START, dert_pkg::FUNC_STOP:
                        begin
                        end
                        default:
                        begin
                            status_next = dert_pkg::STATUS_RANGE;
                            count_next  = 4'd0;
                        end
                    endcase
                    state_next = dert_pkg::ST_IDLE;
                end
            end
            dert_pkg::ST_SCAN:
            begin
                if (step_go)
                begin
                    if (step_hit)
                    begin
                        fired_next = (fired_reg == 4'd15) ? 4'd15 : fired_reg + 4'd1;
                    end
                    if (step_emit)
                    begin
                        listed_next     = listed_reg + 4'd1;
                        out_valid_next  = 1'b1;
                        status_next     = dert_pkg::STATUS_OK;
                        fire_next       = (cmd.op != dert_pkg::OP_REPORT);
                        slot_index_next = 3'(idx_reg);
                        type_out_next   = kind_sel;
                        count_next      = 4'd0;
                        last_next       = 1'b0;
                    end
                    if (idx_reg == IW'(SLOTS - 1))
                    begin
                        state_next = dert_pkg::ST_FINAL;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            dert_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = dert_pkg::STATUS_OK;
                    fire_next       = 1'b0;
                    slot_index_next = 3'd0;
                    type_out_next   = 8'd0;
                    count_next      = fired_reg;
                    last_next       = 1'b1;
                    state_next      = dert_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dert_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dert_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            used_cnt_reg  <= '0;
            window_reg    <= 32'd0;
            fast_reg      <= 32'd1;
            medium_reg    <= 32'd1;
            slow_reg      <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            used_cnt_reg  <= used_cnt_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    dert_pkg::REG_WINDOW: window_reg <= cfg_data;
                    dert_pkg::REG_FAST:   fast_reg   <= cfg_data;
                    dert_pkg::REG_MEDIUM: medium_reg <= cfg_data;
                    default:              slow_reg   <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        listed_reg     <= listed_next;
        fired_reg      <= fired_next;
        status_reg     <= status_next;
        fire_reg       <= fire_next;
        slot_index_reg <= slot_index_next;
        type_out_reg   <= type_out_next;
        count_reg      <= count_next;
        last_reg       <= last_next;
        if (in_valid & in_ready)
        begin
            func_reg  <= func;
            etype_reg <= evt_type;
            value_reg <= event_value;
            cmp_reg   <= compare_op;
            win_reg   <= window_code;
            rlen_reg  <= request_len;
            first_reg <= request_first_byte;
            now_reg   <= now_ms;
        end
    end

endmodule

// File: bench/tb_diagnostic_event_response_table.sv
// Self-checking bench for the event slot table: predicts each transaction's results and compares them.
`timescale 1ns / 1ps

module tb_diagnostic_event_response_table;

    typedef struct packed {
        logic [2:0]  fn;
        logic [7:0]  etype;
        logic [31:0] value;
        logic [7:0]  cmp;
        logic [7:0]  win;
        logic [7:0]  rlen;
        logic [7:0]  first;
        logic [31:0] now;
    } command_t;

    typedef struct packed {
        logic [1:0] st;
        logic       fire;
        logic [2:0] idx;
        logic [7:0] kind;
        logic [3:0] cnt;
        logic       last;
    } answer_t;

    localparam int REQ_MAX   = 32;
    localparam int LIMIT     = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [7:0]  evt_type;
    logic [31:0] event_value;
    logic [7:0]  compare_op;
    logic [7:0]  window_code;
    logic [7:0]  request_len;
    logic [7:0]  request_first_byte;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        fire;
    logic [2:0]  slot_index;
    logic [7:0]  type_out;
    logic [3:0]  count;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    diagnostic_event_response_table uut (.*);

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    int       errors;
    int       cycles;
    int       in_gap;
    int       out_gap;
    bit       calm;
    bit       hold_send;

    logic [31:0] p_window;
    logic [31:0] p_fast;
    logic [31:0] p_medium;
    logic [31:0] p_slow;
    bit          p_used[8];
    bit          p_armed[8];
    bit          p_primed[8];
    logic [7:0]  p_kind[8];
    logic [31:0] p_ref[8];
    logic [7:0]  p_cmp[8];
    logic [7:0]  p_win[8];
    logic [31:0] p_deadline[8];
    logic [31:0] p_next[8];

    function automatic bit time_reached(logic [31:0] t_now, logic [31:0] t);
        logic [31:0] d;
        d = t_now - t;
        return d[31] == 1'b0;
    endfunction

    function automatic int stored_slots();
        int n;
        n = 0;
        for (int i = 0; i < 8; i++)
            if (p_used[i]) n++;
        return n;
    endfunction

    function automatic answer_t mk(logic [1:0] st, logic f, int idx, logic [7:0] k,
                                   int cnt, logic l);
        answer_t a;
        a.st = st;
        a.fire = f;
        a.idx = idx[2:0];
        a.kind = k;
        a.cnt = (cnt > 15) ? 4'd15 : cnt[3:0];
        a.last = l;
        return a;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < 8; i++)
        begin
            p_used[i] = 0;
            p_armed[i] = 0;
            p_primed[i] = 0;
            p_kind[i] = '0;
            p_ref[i] = '0;
            p_cmp[i] = '0;
            p_win[i] = '0;
            p_deadline[i] = '0;
            p_next[i] = '0;
        end
    endfunction

    function automatic void predict_table(command_t c);
        int slot;
        int n;
        logic [7:0] k;
        logic [31:0] per;
        bit hit;
        n = 0;
        slot = -1;
        case (dert_pkg::func_t'(c.fn))
            dert_pkg::FUNC_SETUP:
            begin
                k = c.etype & dert_pkg::KIND_MASK;
                if (k != dert_pkg::KIND_STATUS && k != dert_pkg::KIND_TIMER
                    && k != dert_pkg::KIND_IDENT && k != dert_pkg::KIND_COMPARE)
                    expected_answers.push_back(mk(dert_pkg::STATUS_RANGE, 0, 0, 0, 0, 1));
                else if (c.rlen == 0 || c.rlen > REQ_MAX)
                    expected_answers.push_back(mk(dert_pkg::STATUS_COND, 0, 0, 0, 0, 1));
                else if (c.first == dert_pkg::SID_ROE || c.first == dert_pkg::SID_SECURED)
                    expected_answers.push_back(mk(dert_pkg::STATUS_RANGE, 0, 0, 0, 0, 1));
                else
                begin
                    for (int i = 7; i >= 0; i--)
                        if (!p_used[i]) slot = i;
                    if (slot < 0)
                        expected_answers.push_back(mk(dert_pkg::STATUS_COND, 0, 0, 0, 0, 1));
                    else
                    begin
                        p_used[slot] = 1;
                        p_armed[slot] = 0;
                        p_primed[slot] = 0;
                        p_kind[slot] = k;
                        p_ref[slot] = c.value;
                        p_cmp[slot] = (k == dert_pkg::KIND_COMPARE) ? c.cmp : 8'd0;
                        p_win[slot] = c.win;
                        p_deadline[slot] = '0;
                        p_next[slot] = '0;
                        expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, slot, k,
                                                      stored_slots(), 1));
                    end
                end
            end
            dert_pkg::FUNC_START:
            begin
                for (int i = 0; i < 8; i++)
                    if (p_used[i])
                    begin
                        p_armed[i] = 1;
                        p_deadline[i] = (p_win[i] == dert_pkg::WINDOW_INFINITE) ?
                                        32'd0 : c.now + p_window;
                    end
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, stored_slots(), 1));
            end
            dert_pkg::FUNC_STOP:
            begin
                for (int i = 0; i < 8; i++)
                    p_armed[i] = 0;
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, stored_slots(), 1));
            end
            dert_pkg::FUNC_CLEAR:
            begin
                clear_table();
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, 0, 1));
            end
            dert_pkg::FUNC_REPORT:
            begin
                for (int i = 0; i < 8; i++)
                    if (p_used[i] && p_armed[i])
                    begin
                        expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, i, p_kind[i],
                                                      0, 0));
                        n++;
                    end
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, n, 1));
            end
            dert_pkg::FUNC_TICK:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (!(p_used[i] && p_armed[i])) continue;
                    if (p_win[i] != dert_pkg::WINDOW_INFINITE
                        && time_reached(c.now, p_deadline[i]))
                    begin
                        p_armed[i] = 0;
                        continue;
                    end
                    if (p_kind[i] != dert_pkg::KIND_TIMER) continue;
                    per = (p_ref[i] == dert_pkg::RATE_FAST) ? p_fast :
                          (p_ref[i] == dert_pkg::RATE_MEDIUM) ? p_medium : p_slow;
                    if (!p_primed[i])
                    begin
                        p_primed[i] = 1;
                        p_next[i] = c.now + per;
                    end
                    else if (time_reached(c.now, p_next[i]))
                    begin
                        expected_answers.push_back(mk(dert_pkg::STATUS_OK, 1, i, p_kind[i],
                                                      0, 0));
                        n++;
                        p_next[i] = c.now + per;
                    end
                end
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, n, 1));
            end
            dert_pkg::FUNC_TRIGGER:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (!(p_used[i] && p_armed[i]) || p_kind[i] != c.etype) continue;
                    if (c.etype == dert_pkg::KIND_IDENT)
                        hit = c.value == p_ref[i];
                    else if (c.etype == dert_pkg::KIND_COMPARE)
                        hit = (p_cmp[i] == dert_pkg::CMP_GREATER) ? c.value > p_ref[i] :
                              (p_cmp[i] == dert_pkg::CMP_LESS) ? c.value < p_ref[i] :
                              c.value == p_ref[i];
                    else
                        hit = (c.value & p_ref[i]) != 0;
                    if (!hit) continue;
                    expected_answers.push_back(mk(dert_pkg::STATUS_OK, 1, i, p_kind[i], 0, 0));
                    n++;
                end
                expected_answers.push_back(mk(dert_pkg::STATUS_OK, 0, 0, 0, n, 1));
            end
            default:
                expected_answers.push_back(mk(dert_pkg::STATUS_RANGE, 0, 0, 0, 0, 1));
        endcase
    endfunction

    task automatic report_mismatch(string what, answer_t got, answer_t want);
        $display("mismatch %s: got %p want %p", what, got, want);
        errors++;
    endtask

    function automatic command_t make_cmd(dert_pkg::func_t f, logic [7:0] et, logic [31:0] v,
                                          logic [7:0] cp, logic [7:0] w, logic [31:0] t);
        command_t c;
        c.fn = f;
        c.etype = et;
        c.value = v;
        c.cmp = cp;
        c.win = w;
        c.rlen = 8'd1 + 8'($urandom_range(0, 31));
        c.first = 8'($urandom_range(0, 127));
        c.now = t;
        return c;
    endfunction

    function automatic command_t random_cmd(logic [31:0] t);
        command_t c;
        logic [7:0] kinds[4] = '{dert_pkg::KIND_STATUS, dert_pkg::KIND_TIMER,
                                 dert_pkg::KIND_IDENT, dert_pkg::KIND_COMPARE};
        int r;
        r = $urandom_range(0, 99);
        c = make_cmd(dert_pkg::FUNC_SETUP,
                     kinds[$urandom_range(0, 3)] | (8'($urandom_range(0, 1)) << 7),
                     $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 4)),
                     8'($urandom_range(1, 4)), $urandom_range(0, 1) ? dert_pkg::WINDOW_INFINITE
                     : 8'($urandom), t);
        if (r < 20)
            c.fn = dert_pkg::FUNC_SETUP;
        else if (r < 30)
            c.fn = dert_pkg::FUNC_START;
        else if (r < 34)
            c.fn = dert_pkg::FUNC_STOP;
        else if (r < 38)
            c.fn = dert_pkg::FUNC_CLEAR;
        else if (r < 46)
            c.fn = dert_pkg::FUNC_REPORT;
        else if (r < 70)
            c.fn = dert_pkg::FUNC_TICK;
        else if (r < 97)
        begin
            c.fn = dert_pkg::FUNC_TRIGGER;
            c.etype = kinds[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0) c.etype = 8'($urandom);
        end
        else
        begin
            c = make_cmd(dert_pkg::func_t'($urandom_range(0, 7)), 8'($urandom), $urandom,
                         8'($urandom), 8'($urandom), $urandom);
            c.rlen = 8'($urandom);
            c.first = 8'($urandom);
        end
        if ($urandom_range(0, 19) == 0)
            c.rlen = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(33, 255));
        if ($urandom_range(0, 24) == 0)
            c.first = $urandom_range(0, 1) ? dert_pkg::SID_ROE : dert_pkg::SID_SECURED;
        if ($urandom_range(0, 9) == 0) c.first = 8'($urandom);
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dert_pkg::REG_WINDOW: p_window = data;
            dert_pkg::REG_FAST:   p_fast = data;
            dert_pkg::REG_MEDIUM: p_medium = data;
            default:              p_slow = data;
        endcase
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_answers.size() != 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                predict_table(pending_cmds.pop_front());
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && !hold_send)
            begin
                command_t c;
                c = pending_cmds[0];
                in_valid <= 1'b1;
                func <= c.fn;
                evt_type <= c.etype;
                event_value <= c.value;
                compare_op <= c.cmp;
                window_code <= c.win;
                request_len <= c.rlen;
                request_first_byte <= c.first;
                now_ms <= c.now;
                if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
            cycles <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (cycles > LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                answer_t got;
                got = '{status, fire, slot_index, type_out, count, last};
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected", got, '0);
                else if (got != expected_answers[0])
                    report_mismatch("field", got, expected_answers.pop_front());
                else
                    void'(expected_answers.pop_front());
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_gap <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] t;
        errors = 0;
        calm = 0;
        hold_send = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        func = '0;
        evt_type = '0;
        event_value = '0;
        compare_op = '0;
        window_code = '0;
        request_len = '0;
        request_first_byte = '0;
        now_ms = '0;
        p_window = 0;
        p_fast = 1;
        p_medium = 1;
        p_slow = 1;
        clear_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(dert_pkg::REG_WINDOW, 32'd100);
        write_reg(dert_pkg::REG_FAST, 32'd5);
        write_reg(dert_pkg::REG_MEDIUM, 32'd10);
        write_reg(dert_pkg::REG_SLOW, 32'd20);
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, 8'h05, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS,
                                        32'hFFFF_FFFF, 0, 0, 0));
        pending_cmds[1].rlen = 0;
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS, 1, 0, 0, 0));
        pending_cmds[2].rlen = 8'hFF;
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS, 1, 0, 0, 0));
        pending_cmds[3].first = dert_pkg::SID_ROE;
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS, 1, 0, 0, 0));
        pending_cmds[4].first = dert_pkg::SID_SECURED;
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS,
                                        32'h8000_0001, 0, 8'hFF, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_TIMER | 8'h80,
                                        dert_pkg::RATE_FAST, 0, dert_pkg::WINDOW_INFINITE, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_IDENT,
                                        32'h1234, 9, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_COMPARE, 50,
                                        dert_pkg::CMP_GREATER, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_COMPARE, 50,
                                        dert_pkg::CMP_LESS, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_COMPARE, 50,
                                        8'hFF, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_TIMER,
                                        dert_pkg::RATE_MEDIUM, 0, dert_pkg::WINDOW_INFINITE, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_TIMER, 1, 0,
                                        dert_pkg::WINDOW_INFINITE, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_SETUP, dert_pkg::KIND_STATUS, 1, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_START, 0, 0, 0, 0, 32'hFFFF_FFF0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_REPORT, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TRIGGER, dert_pkg::KIND_COMPARE,
                                        50, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TRIGGER, dert_pkg::KIND_COMPARE,
                                        51, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TRIGGER, dert_pkg::KIND_IDENT,
                                        32'h1234, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TRIGGER, dert_pkg::KIND_STATUS,
                                        32'h8000_0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFF8));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TICK, 0, 0, 0, 0, 32'h0000_0010));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_TICK, 0, 0, 0, 0, 32'h0000_0080));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                                        8'hFF, 32'hFFFF_FFFF));
        pending_cmds[24].rlen = 8'hFF;
        pending_cmds[24].first = 8'hFF;
        pending_cmds.push_back(make_cmd(dert_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(dert_pkg::REG_WINDOW, 32'hFFFF_FFFF);
                    write_reg(dert_pkg::REG_FAST, 32'd1);
                    write_reg(dert_pkg::REG_MEDIUM, 32'hFFFF_FFFF);
                    write_reg(dert_pkg::REG_SLOW, 32'd3);
                end
                1:
                begin
                    write_reg(dert_pkg::REG_WINDOW, 32'd0);
                    write_reg(dert_pkg::REG_FAST, 32'd2);
                    write_reg(dert_pkg::REG_MEDIUM, 32'd4);
                    write_reg(dert_pkg::REG_SLOW, 32'h7FFF_FFFF);
                end
                2:
                begin
                    write_reg(dert_pkg::REG_WINDOW, 32'd60);
                    write_reg(dert_pkg::REG_SLOW, 32'd7);
                end
                default:
                begin
                    calm = 1;
                    write_reg(dert_pkg::REG_WINDOW, $urandom_range(10, 400));
                    write_reg(dert_pkg::REG_FAST, $urandom_range(1, 9));
                end
            endcase
            t = $urandom;
            for (int i = 0; i < 78; i++)
            begin
                t = t + $urandom_range(0, 12);
                pending_cmds.push_back(random_cmd(t));
            end
            if (phase == 1)
            begin
                while (pending_cmds.size() > 40) @(posedge clk);
                hold_send = 1;
                while (expected_answers.size() != 0 || in_valid) @(posedge clk);
                hold_send = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: diagnostic_event_response_table.f
design/dert_pkg.sv
design/dert_cell.sv
design/diagnostic_event_response_table.sv
bench/tb_diagnostic_event_response_table.sv
